FILE: rtl/cpsp_pkg.sv
`default_nettype none

package cpsp_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_ADDR_W = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TIMEOUT = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_PERIOD = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOOT_FALLBK  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BOOT_MIN     = 8'd3;

    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd10000;
    localparam logic [TIME_W-1:0] CHECK_PERIOD_RST = 32'd500;
    localparam logic [TIME_W-1:0] BOOT_FALLBK_RST  = 32'd30000;
    localparam logic [TIME_W-1:0] BOOT_MIN_RST     = 32'd2000;

    // Event kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        MODE_BOOT   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_IDLE   = 2'd2
    } cpsp_mode_t;

    typedef enum logic [1:0] {
        ACT_KEEP = 2'd0,
        ACT_AUTO = 2'd1,
        ACT_MENU = 2'd2,
        ACT_IDLE = 2'd3
    } cpsp_action_t;

    typedef struct packed {
        logic [TIME_W-1:0] idle_timeout;
        logic [TIME_W-1:0] check_period;
        logic [TIME_W-1:0] boot_fallback;
        logic [TIME_W-1:0] boot_min;
    } cpsp_cfg_t;

    typedef struct packed {
        cpsp_mode_t        mode;
        logic [TIME_W-1:0] boot_origin;
        logic [TIME_W-1:0] next_check;
        logic [TIME_W-1:0] input_stamp;
    } cpsp_state_t;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] now;
        logic              user_input;
        logic              boot_ready;
    } cpsp_item_t;

endpackage

`default_nettype wire

FILE: rtl/cpsp_cfg.sv
`default_nettype none

module cpsp_cfg
    import cpsp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cpsp_cfg_t                  cfg
);

    cpsp_cfg_t cfg_reg;
    cpsp_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            // drop writes beyond the register list
            if (cfg_addr == REG_IDLE_TIMEOUT) begin
                cfg_next.idle_timeout = cfg_wdata[TIME_W-1:0];
            end else if (cfg_addr == REG_CHECK_PERIOD) begin
                cfg_next.check_period = cfg_wdata[TIME_W-1:0];
            end else if (cfg_addr == REG_BOOT_FALLBK) begin
                cfg_next.boot_fallback = cfg_wdata[TIME_W-1:0];
            end else if (cfg_addr == REG_BOOT_MIN) begin
                cfg_next.boot_min = cfg_wdata[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_timeout  <= IDLE_TIMEOUT_RST;
            cfg_reg.check_period  <= CHECK_PERIOD_RST;
            cfg_reg.boot_fallback <= BOOT_FALLBK_RST;
            cfg_reg.boot_min      <= BOOT_MIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/cpsp_policy.sv
`default_nettype none

module cpsp_policy
    import cpsp_pkg::*;
(
    input  wire cpsp_cfg_t   cfg,
    input  wire cpsp_state_t state,
    input  wire cpsp_item_t  item,
    output cpsp_state_t      state_next,
    output cpsp_action_t     action
);

    logic [TIME_W-1:0] last_eff;
    logic [TIME_W-1:0] since_input;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] to_check;
    logic [TIME_W-1:0] check_next;
    logic              idle_hit;
    logic              fallback_hit;
    logic              before_min;
    logic              not_due;
    cpsp_mode_t        exit_mode;
    cpsp_action_t      exit_act;

    // Input on this tick refreshes the timestamp before any idle test
    assign last_eff     = item.user_input ? item.now : state.input_stamp;
    assign since_input  = item.now - last_eff;
    assign idle_hit     = since_input >= cfg.idle_timeout;
    assign elapsed      = item.now - state.boot_origin;
    assign fallback_hit = elapsed >= cfg.boot_fallback;
    assign before_min   = elapsed < cfg.boot_min;
    assign to_check     = item.now - state.next_check;
    assign not_due      = to_check[TIME_W-1];
    assign check_next   = item.now + cfg.check_period;
    assign exit_mode    = idle_hit ? MODE_IDLE : MODE_ACTIVE;
    assign exit_act     = idle_hit ? ACT_IDLE : ACT_MENU;

    always_comb begin
        state_next = state;
        action     = ACT_KEEP;
        if (item.op == OP_START) begin
            state_next.boot_origin = item.now;
            state_next.next_check  = check_next;
            state_next.input_stamp = item.now;
            state_next.mode        = item.boot_ready ? MODE_ACTIVE : MODE_BOOT;
            action                 = item.boot_ready ? ACT_MENU : ACT_AUTO;
        end else begin
            state_next.input_stamp = last_eff;
            unique case (state.mode)
                MODE_BOOT: begin
                    if (fallback_hit) begin
                        state_next.mode = exit_mode;
                        action          = exit_act;
                    end else if (!before_min && !not_due) begin
                        // reschedule the check whether or not boot is done
                        state_next.next_check = check_next;
                        if (item.boot_ready) begin
                            state_next.mode = exit_mode;
                            action          = exit_act;
                        end
                    end
                end
                MODE_ACTIVE: begin
                    if (idle_hit) begin
                        state_next.mode = MODE_IDLE;
                        action          = ACT_IDLE;
                    end
                end
                MODE_IDLE: begin
                    if (item.user_input) begin
                        state_next.mode = MODE_ACTIVE;
                        action          = ACT_MENU;
                    end
                end
                default: begin
                    action = ACT_KEEP;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cpu_speed_policy_fsm.sv
// CPU clock policy with boot, active and idle modes. Every item on the s_
// channel is one timestamped event and yields exactly one action item on the
// m_ channel (keep, set auto, set menu speed, set idle speed), in order. An
// accepted item sits in the input register, where the policy logic reads it
// together with the mode and timestamp registers; the action is written into
// the output register and the state is updated in the same edge. m_tvalid
// rises when the item moves into the output register (two register stages),
// and one item is taken every cycle as long as m_tready stays high; the
// single input register and the output register set that figure. The user
// must write timing registers through the cfg_ port only while no item is
// in flight (not enforced); writes to indexes four and above are dropped.
`default_nettype none

module cpu_speed_policy_fsm
    import cpsp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [39:0]           s_tdata,   // now[31:0], user_input, boot_ready, zeros
    input  wire logic                  s_tuser,   // op

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [7:0]            m_tdata    // action[1:0], zeros
);

    cpsp_cfg_t    cfg;
    cpsp_state_t  state_reg;
    cpsp_state_t  state_next;
    cpsp_item_t   item_reg;
    cpsp_item_t   item_in;
    cpsp_action_t action_next;
    cpsp_action_t action_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         s_take;

    cpsp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cpsp_policy u_policy (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .action     (action_next)
    );

    assign item_in.op         = s_tuser;
    assign item_in.now        = s_tdata[TIME_W-1:0];
    assign item_in.user_input = s_tdata[TIME_W];
    assign item_in.boot_ready = s_tdata[TIME_W+1];

    // move the held item into the output register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.mode        <= MODE_BOOT;
            state_reg.boot_origin <= '0;
            state_reg.next_check  <= '0;
            state_reg.input_stamp <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= item_in;
        end
        if (advance) begin
            action_reg <= action_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, action_reg};

`ifndef SYNTHESIS
    a_start_action: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.op == OP_START
        |=> m_tvalid && (action_reg == ACT_MENU || action_reg == ACT_AUTO))
        else $error("start item gave an action other than menu or auto");

    a_boot_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.op == OP_UPDATE && state_reg.mode == MODE_BOOT
        |=> (action_reg == ACT_KEEP) == (state_reg.mode == MODE_BOOT))
        else $error("boot mode left without a speed change, or kept with one");

    a_idle_action: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.op == OP_UPDATE && state_reg.mode == MODE_IDLE
        |=> action_reg == ACT_KEEP || action_reg == ACT_MENU)
        else $error("idle mode gave an action other than keep or menu");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while the pipeline could move");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("policy state changed without an item");
`endif

endmodule

`default_nettype wire

FILE: verif/cpsp_action_checker.sv
`timescale 1ns / 1ps

module cpsp_action_checker
    import cpsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,   // now[31:0], user_input, boot_ready, zeros
    input  logic                  s_tuser,   // op

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // action[1:0], zeros

    output int unsigned           fail_count,
    output int unsigned           actions_pending
);

    cpsp_cfg_t    timing;
    cpsp_state_t  policy;
    cpsp_action_t expected_actions[$];

    function automatic logic idle_timeout_hit(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since_input;
        since_input = now - policy.input_stamp;
        return since_input >= timing.idle_timeout;
    endfunction

    function automatic cpsp_action_t leave_boot(input logic [TIME_W-1:0] now);
        if (idle_timeout_hit(now)) begin
            policy.mode = MODE_IDLE;
            return ACT_IDLE;
        end
        policy.mode = MODE_ACTIVE;
        return ACT_MENU;
    endfunction

    // Advance the policy state by one event and return the action it yields.
    function automatic cpsp_action_t policy_action(input cpsp_item_t ev);
        logic [TIME_W-1:0] boot_elapsed;
        logic [TIME_W-1:0] past_check;
        if (ev.op == OP_START) begin
            policy.boot_origin = ev.now;
            policy.next_check  = ev.now + timing.check_period;
            policy.input_stamp = ev.now;
            if (ev.boot_ready) begin
                policy.mode = MODE_ACTIVE;
                return ACT_MENU;
            end
            policy.mode = MODE_BOOT;
            return ACT_AUTO;
        end
        if (ev.user_input)
            policy.input_stamp = ev.now;
        case (policy.mode)
            MODE_BOOT: begin
                boot_elapsed = ev.now - policy.boot_origin;
                past_check   = ev.now - policy.next_check;
                if (boot_elapsed >= timing.boot_fallback)
                    return leave_boot(ev.now);
                // a check is due when the signed distance to it is not negative
                if (boot_elapsed < timing.boot_min || past_check[TIME_W-1])
                    return ACT_KEEP;
                policy.next_check = ev.now + timing.check_period;
                if (ev.boot_ready)
                    return leave_boot(ev.now);
                return ACT_KEEP;
            end
            MODE_ACTIVE: begin
                if (idle_timeout_hit(ev.now)) begin
                    policy.mode = MODE_IDLE;
                    return ACT_IDLE;
                end
                return ACT_KEEP;
            end
            MODE_IDLE: begin
                if (ev.user_input) begin
                    policy.mode = MODE_ACTIVE;
                    return ACT_MENU;
                end
                return ACT_KEEP;
            end
            default: return ACT_KEEP;
        endcase
    endfunction

    task automatic report_fault(input string what);
        if (fail_count < 10)
            $display("%0t checker: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        cpsp_item_t   ev;
        cpsp_action_t want;
        if (!aresetn) begin
            timing = '{IDLE_TIMEOUT_RST, CHECK_PERIOD_RST, BOOT_FALLBK_RST, BOOT_MIN_RST};
            policy = '{MODE_BOOT, '0, '0, '0};
            expected_actions.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_IDLE_TIMEOUT: timing.idle_timeout  = cfg_wdata;
                    REG_CHECK_PERIOD: timing.check_period  = cfg_wdata;
                    REG_BOOT_FALLBK:  timing.boot_fallback = cfg_wdata;
                    REG_BOOT_MIN:     timing.boot_min      = cfg_wdata;
                    default: ;
                endcase
            end
            // retire first: a result can never belong to the item taken at this edge
            if (m_tvalid && m_tready) begin
                if (expected_actions.size() == 0) begin
                    report_fault($sformatf("unexpected action item %0d", m_tdata[1:0]));
                end else begin
                    want = expected_actions.pop_front();
                    if (m_tdata[1:0] !== want)
                        report_fault($sformatf("action mismatch: expected %s (%0d), got %0d",
                                               want.name(), want, m_tdata[1:0]));
                end
            end
            if (s_tvalid && s_tready) begin
                ev.op         = s_tuser;
                ev.now        = s_tdata[31:0];
                ev.user_input = s_tdata[32];
                ev.boot_ready = s_tdata[33];
                expected_actions.push_back(policy_action(ev));
            end
        end
        actions_pending = expected_actions.size();
    end

endmodule

FILE: verif/tb_cpu_speed_policy_fsm.sv
`timescale 1ns / 1ps

module tb_cpu_speed_policy_fsm;
    import cpsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_UNMAPPED = 8'd4;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;

    int unsigned fail_count;
    int unsigned actions_pending;
    int unsigned cycle_count = 0;

    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;
    bit hold_off_req = 1'b0;

    cpu_speed_policy_fsm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cpsp_action_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .actions_pending (actions_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_cpu_speed_policy_fsm failed");
        $finish;
    end

    // mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Called and returns at a falling edge.
    task automatic send_event(input logic op, input logic [TIME_W-1:0] now,
                              input logic user_input, input logic boot_ready);
        int unsigned gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, boot_ready, user_input, now};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (actions_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_timing(input logic [TIME_W-1:0] idle_timeout,
                                input logic [TIME_W-1:0] check_period,
                                input logic [TIME_W-1:0] boot_fallback,
                                input logic [TIME_W-1:0] boot_min);
        logic [CFG_ADDR_W-1:0] stray_idx;
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_IDLE_TIMEOUT, idle_timeout);
        write_reg(REG_CHECK_PERIOD, check_period);
        write_reg(REG_BOOT_FALLBK, boot_fallback);
        write_reg(REG_BOOT_MIN, boot_min);
        // writes past the last register must be dropped
        stray_idx = REG_FIRST_UNMAPPED + CFG_ADDR_W'($urandom_range(0, 251));
        write_reg(stray_idx, $urandom());
    endtask

    // Mostly a start followed by a run of updates on a moving clock, plus noise.
    task automatic run_traffic(input int unsigned count, input logic [TIME_W-1:0] step_max);
        int unsigned       sent;
        int unsigned       run_len;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] step;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 3))
                    0: t = $urandom_range(0, 1000);
                    1: t = TIME_MAX - $urandom_range(0, 4000);
                    default: t = $urandom();
                endcase
                send_event(OP_START, t, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
                run_len = $urandom_range(3, 30);
                repeat (run_len) begin
                    step = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, step_max);
                    t += step;
                    send_event(OP_UPDATE, t, $urandom_range(0, 3) == 0,
                               $urandom_range(0, 2) == 0);
                end
                sent += run_len + 1;
            end else begin
                send_event(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Walk the reset timing through every mode and transition.
    task automatic run_directed();
        send_event(OP_UPDATE, 32'd0,        1'b0, 1'b0); // tick before any start
        send_event(OP_UPDATE, TIME_MAX,     1'b1, 1'b1); // boot fallback from reset state
        send_event(OP_START,  32'd1000,     1'b0, 1'b0);
        send_event(OP_UPDATE, 32'd1500,     1'b0, 1'b1); // below minimum boot time
        send_event(OP_UPDATE, 32'd3000,     1'b0, 1'b0); // check due, not done
        send_event(OP_UPDATE, 32'd3200,     1'b0, 1'b1); // done but no check due
        send_event(OP_UPDATE, 32'd3500,     1'b0, 1'b1); // check due and done
        send_event(OP_UPDATE, 32'd13500,    1'b0, 1'b0); // active times out
        send_event(OP_UPDATE, 32'd14000,    1'b1, 1'b0); // input wakes idle
        send_event(OP_UPDATE, 32'd24000,    1'b0, 1'b0);
        send_event(OP_START,  32'hFFFFFF00, 1'b1, 1'b0); // start just before wrap
        send_event(OP_UPDATE, 32'h00000100, 1'b0, 1'b1);
        send_event(OP_UPDATE, 32'hFFFFFF00 + 32'd30000, 1'b0, 1'b0); // fallback into idle
        send_event(OP_START,  32'd5,        1'b0, 1'b1); // boot already finished
        send_event(OP_UPDATE, 32'd5,        1'b1, 1'b0);
        send_event(OP_UPDATE, TIME_MAX,     1'b0, 1'b0);
        send_event(OP_UPDATE, TIME_MAX,     1'b0, 1'b1);
        send_event(OP_START,  32'h80000000, 1'b1, 1'b1);
        send_event(OP_UPDATE, 32'h7FFFFFFF, 1'b1, 1'b1);
        send_event(OP_START,  32'h55555555, 1'b0, 1'b0);
        send_event(OP_UPDATE, 32'hAAAAAAAA, 1'b1, 1'b1);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        run_traffic(250, 3000);

        apply_timing(50, 10, 300, 40);
        run_traffic(250, 60);

        // hold the result side off while items keep coming, then pause until all are out
        drain();
        hold_off_req = 1'b1;
        tx_gaps = 1'b0;
        run_traffic(24, 60);
        drain();

        // a stretch with no idling on either side
        rx_stalls = 1'b0;
        run_traffic(150, 60);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;

        apply_timing('0, '0, '0, '0);
        run_traffic(120, 20);
        apply_timing('1, '1, '1, '1);
        run_traffic(120, TIME_MAX);
        apply_timing('0, '1, 1000, '0);
        run_traffic(120, 400);
        apply_timing('1, 1, 200, '0);
        run_traffic(100, 100);
        repeat (4) begin
            apply_timing($urandom_range(0, 200), $urandom_range(0, 50),
                         $urandom_range(0, 600), $urandom_range(0, 300));
            run_traffic(100, 80);
        end

        drain();
        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("tb_cpu_speed_policy_fsm passed");
        else
            $display("tb_cpu_speed_policy_fsm failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/cpsp_pkg.sv
rtl/cpsp_cfg.sv
rtl/cpsp_policy.sv
rtl/cpu_speed_policy_fsm.sv
verif/cpsp_action_checker.sv
verif/tb_cpu_speed_policy_fsm.sv
